// ----- rtl/rme_pkg.sv -----
`default_nettype none
// ============================================================================
// rme_pkg: shared types and constants for the Euler angle core
// Beat structs, the CORDIC angle table and output angle limits.
// ============================================================================
package rme_pkg;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] forward_x;
        logic signed [15:0] forward_y;
        logic signed [15:0] forward_z;
        logic signed [15:0] up_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               not_unique;
    } t_out_beat;

    // Side information that travels with each beat through the pipeline.
    typedef struct packed {
        logic [1:0] mode;
    } t_side;

    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_LOCK_UP   = 2'd1;
    localparam logic [1:0] MODE_LOCK_DOWN = 2'd2;

    localparam int TABLE_LEN = 24;
    // Angle accumulator: units of 2^-24 rad.
    localparam int ANG_W = 28;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;
    localparam logic signed [15:0] OUT_PI      = 16'sd25736;
    localparam logic signed [15:0] OUT_HALF_PI = 16'sd12868;
    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;

    // Datapath width: operands are scaled by 2^16; growth stays below 2^34.
    localparam int DW = 36;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:  v = 28'sd13176795;
            5'd1:  v = 28'sd7778716;
            5'd2:  v = 28'sd4110060;
            5'd3:  v = 28'sd2086331;
            5'd4:  v = 28'sd1047214;
            5'd5:  v = 28'sd524117;
            5'd6:  v = 28'sd262123;
            5'd7:  v = 28'sd131069;
            5'd8:  v = 28'sd65536;
            5'd9:  v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage : rme_pkg
`default_nettype wire

// ----- rtl/rotation_matrix_to_euler_xyz_core.sv -----
`default_nettype none
// ============================================================================
// rotation_matrix_to_euler_xyz_core: XYZ Euler angles from a rotation matrix
// Pipelined CORDIC conversion of seven Q2.14 matrix entries to Q3.13 angles.
// ============================================================================
// The core accepts one matrix beat per clock, unless the output stalls, and
// returns one angle beat per input beat, in order. Beats pass through input
// decode, the square root, the CORDIC stages with their entry and rounding
// registers, and the output mux. The square root for the y angle runs first;
// the x and z arctangents are delayed to line up with it, so three CORDIC
// pipelines run side by side. The whole pipeline advances only when the
// output register can move, so a stall at the output holds every stage and
// no beat is lost or repeated.
// ============================================================================
module rotation_matrix_to_euler_xyz_core
    import rme_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_beat  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_beat      o_data
);
    localparam int NS    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int SQ_LAT = 15;
    localparam int CO_LAT = NS + 2;
    localparam int LAT   = 1 + SQ_LAT + CO_LAT;

    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // Stage one: classify and register the operands.
    t_in_beat            r_in;
    t_side               r_side;
    logic [28:0]         r_rem;
    logic signed [31:0]  rz_sq;
    t_side               n_side;

    always_comb begin
        rz_sq = 32'(i_data.right_z) * 32'(i_data.right_z);
        if (i_data.right_z >= Q14_ONE)
            n_side.mode = MODE_LOCK_UP;
        else if (i_data.right_z <= -Q14_ONE)
            n_side.mode = MODE_LOCK_DOWN;
        else
            n_side.mode = MODE_NORMAL;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in   <= i_data;
            r_side <= n_side;
            r_rem  <= 29'(32'sd268435456 - rz_sq);
        end
    end

    // Square root runs while the other operands wait in a delay line.
    logic [14:0] root;
    rme_sqrt_pipe u_sqrt (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_val (r_rem),
        .o_root(root)
    );

    t_in_beat r_dly_in   [SQ_LAT];
    t_side    r_dly_side [SQ_LAT];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly_in[0]   <= r_in;
            r_dly_side[0] <= r_side;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_dly_in[k]   <= r_dly_in[k-1];
                r_dly_side[k] <= r_dly_side[k-1];
            end
        end
    end

    t_in_beat d_in;
    t_side    d_side;
    logic     lock;
    assign d_in   = r_dly_in[SQ_LAT-1];
    assign d_side = r_dly_side[SQ_LAT-1];
    assign lock   = d_side.mode != MODE_NORMAL;

    // CORDIC operands: lock cases reuse the x unit for atan2(fwd.x, fwd.y).
    logic signed [16:0] ax_y, ax_x, ay_y, ay_x, az_y, az_x;
    always_comb begin
        if (lock) begin
            ax_y = 17'(d_in.forward_x);
            ax_x = 17'(d_in.forward_y);
        end else begin
            ax_y = -17'(d_in.forward_z);
            ax_x = 17'(d_in.up_z);
        end
        ay_y = 17'(d_in.right_z);
        ay_x = 17'(signed'({2'b00, root}));
        az_y = -17'(d_in.right_y);
        az_x = 17'(d_in.right_x);
    end

    logic signed [15:0] ang_x, ang_y, ang_z;
    rme_cordic_pipe #(.STAGES(CORDIC_STAGES)) u_cx (
        .i_clk(i_clk), .i_en(adv), .i_y(ax_y), .i_x(ax_x), .o_angle(ang_x));
    rme_cordic_pipe #(.STAGES(CORDIC_STAGES)) u_cy (
        .i_clk(i_clk), .i_en(adv), .i_y(ay_y), .i_x(ay_x), .o_angle(ang_y));
    rme_cordic_pipe #(.STAGES(CORDIC_STAGES)) u_cz (
        .i_clk(i_clk), .i_en(adv), .i_y(az_y), .i_x(az_x), .o_angle(ang_z));

    t_side r_co_side [CO_LAT];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_co_side[0] <= d_side;
            for (int k = 1; k < CO_LAT; k++)
                r_co_side[k] <= r_co_side[k-1];
        end
    end

    // Valid bits travel alongside the data through every stage.
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (adv) begin
            r_vld   <= {r_vld[LAT-2:0], i_valid};
            o_valid <= r_vld[LAT-1];
        end
    end

    // Output mux: lock cases override y and z; lock down also negates x.
    t_side     e_side;
    t_out_beat n_out;
    assign e_side = r_co_side[CO_LAT-1];
    always_comb begin
        n_out.angle_x    = ang_x;
        n_out.angle_y    = ang_y;
        n_out.angle_z    = ang_z;
        n_out.not_unique = 1'b0;
        unique case (e_side.mode)
            MODE_LOCK_UP: begin
                n_out.angle_y    = OUT_HALF_PI;
                n_out.angle_z    = '0;
                n_out.not_unique = 1'b1;
            end
            MODE_LOCK_DOWN: begin
                n_out.angle_x    = -ang_x;
                n_out.angle_y    = -OUT_HALF_PI;
                n_out.angle_z    = '0;
                n_out.not_unique = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv)
            o_data <= n_out;
    end

    // A stalled result must hold until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed under stall");
    // Lock results always carry zero z.
    a_lock_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.not_unique |-> o_data.angle_z == 16'sd0)
        else $error("lock result with nonzero z");
    // Output angle x stays within +/-pi.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.angle_x <= OUT_PI) && (o_data.angle_x >= -OUT_PI))
        else $error("angle x out of range");
endmodule : rotation_matrix_to_euler_xyz_core
`default_nettype wire

// ----- rtl/rme_sqrt_pipe.sv -----
`default_nettype none
// ============================================================================
// rme_sqrt_pipe: pipelined integer square root
// Floor square root of a 29-bit value, one result bit per stage, 15 stages.
// ============================================================================
module rme_sqrt_pipe
    import rme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [28:0] i_val,
    output logic      [14:0] o_root
);
    localparam int STEPS = 15;

    // Trial squaring: each stage decides one root bit, high bit first.
    logic [28:0] r_rem  [STEPS];
    logic [14:0] r_root [STEPS];

    logic [28:0] n_rem  [STEPS];
    logic [14:0] n_root [STEPS];

    always_comb begin
        for (int s = 0; s < STEPS; s++) begin
            logic [28:0] rin;
            logic [14:0] qin;
            logic [14:0] trial;
            logic [29:0] sq;
            rin   = (s == 0) ? i_val : r_rem[s-1];
            qin   = (s == 0) ? 15'd0 : r_root[s-1];
            trial = qin | (15'd1 << (STEPS - 1 - s));
            sq    = {15'd0, trial} * {15'd0, trial};
            n_rem[s]  = rin;
            n_root[s] = (sq <= {1'b0, rin}) ? trial : qin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STEPS; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_root = r_root[STEPS-1];
endmodule : rme_sqrt_pipe
`default_nettype wire

// ----- rtl/rme_cordic_pipe.sv -----
`default_nettype none
// ============================================================================
// rme_cordic_pipe: pipelined CORDIC vectoring unit
// Computes atan2(y, x) rounded to Q3.13 and saturated to +/-pi.
// ============================================================================
module rme_cordic_pipe
    import rme_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [16:0] i_y,
    input  wire logic signed [16:0] i_x,
    output logic signed      [15:0] o_angle
);
    localparam int NS = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;

    logic signed [DW-1:0]    r_x [NS+1];
    logic signed [DW-1:0]    r_y [NS+1];
    logic signed [ANG_W-1:0] r_z [NS+1];
    logic                    r_zero [NS+1];
    logic signed [15:0]      r_out;

    logic signed [DW-1:0]    n_x0, n_y0, xs, ys;
    logic signed [ANG_W-1:0] n_z0;
    logic signed [ANG_W:0]   zr;
    logic signed [ANG_W-11:0] zq;
    logic signed [15:0]      n_out;

    // Prerotation into the right half plane.
    always_comb begin
        xs = DW'(i_x) <<< 16;
        ys = DW'(i_y) <<< 16;
        n_x0 = xs;
        n_y0 = ys;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = ys;
                n_y0 = -xs;
                n_z0 = ANG_HALF_PI;
            end else begin
                n_x0 = -ys;
                n_y0 = xs;
                n_z0 = -ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
            for (int i = 0; i < NS; i++) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_entry(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_entry(5'(i));
                end
                r_zero[i+1] <= r_zero[i];
            end
            r_out <= n_out;
        end
    end

    // Round half up, then saturate.
    always_comb begin
        zr = (ANG_W+1)'(r_z[NS]) + (ANG_W+1)'(1024);
        zq = (ANG_W-10)'(zr >>> 11);
        if (r_zero[NS])
            n_out = '0;
        else if (zq > (ANG_W-10)'(OUT_PI))
            n_out = OUT_PI;
        else if (zq < -(ANG_W-10)'(OUT_PI))
            n_out = -OUT_PI;
        else
            n_out = 16'(zq);
    end

    assign o_angle = r_out;
endmodule : rme_cordic_pipe
`default_nettype wire
